/* rtl/qct_pkg.sv */
// qct_pkg: shared types and constants of the quantized cost table
// no dependencies
`default_nettype none
package qct_pkg;
	typedef enum logic [1:0] {
		OP_QUERY = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_DUMP  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_UPD,
		ST_RES,
		ST_DSCAN,
		ST_DRD,
		ST_DMUL,
		ST_DOUT
	} state_t;

	localparam int unsigned IDXW  = 16;
	localparam int unsigned FEATW = 32;
	localparam int unsigned SIZEW = 31;
	localparam int unsigned NDIMS = 4;
	localparam int unsigned NREGS = 4;
	localparam logic signed [IDXW-1:0] IDX_MAX = 16'sh7fff;
	localparam logic signed [IDXW-1:0] IDX_MIN = -16'sh8000;
	localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] C_MIN = -32'sh80000000;
endpackage
`default_nettype wire

/* rtl/quantized_cost_table.sv */
// quantized_cost_table: quantizes features to bucket indices, keeps a sparse cost table
// depends on qct_pkg
//
// channel   dir  tdata fields (low bit up)                         tuser / tlast
// s_axis    in   operation, feature_0..3, delta (162 bits -> 168)   -
// m_axis    out  cost, found, full_res, index_0..3, bucket_value_0..3 tlast = last
// cfg       in   cfg_we, cfg_index[1:0], cfg_data[30:0]            -
//
// one item at a time. query and add: per dimension a restoring divide, one quotient bit
// per step, then a step to saturate the index; then a scan of every slot behind the
// registered memory read, an update step, one multiply per dimension and a result step.
// clear: the accept, then the result step. dump: scans each empty slot and, per valid
// entry, reads it, multiplies each dimension and then outputs it.
// reset clears the valid bits; key and cost memories are undefined until written.
// a stalled result holds in the output register until m_axis_tready.
`default_nettype none
module quantized_cost_table
	import qct_pkg::*;
#(
	parameter int unsigned DIMS     = 2,
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// operation[1:0], feature_0[33:2], feature_1, feature_2, feature_3, delta[161:130]
	input  wire logic [167:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// cost[31:0], found[32], full_res[33], index_0..3[97:34], bucket_value_0..3[225:98]
	output logic [231:0]      m_axis_tdata,
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [30:0]  cfg_data
);
	localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned DW = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam logic [SW:0] CAP = (SW+1)'(CAPACITY);
	localparam logic [DW:0] ND  = (DW+1)'(DIMS);

	state_t state_q, state_n;

	logic [SIZEW-1:0] bsize_q [NDIMS];
	op_t              op_q;
	logic [FEATW-1:0] feat_q [NDIMS];
	logic signed [31:0] delta_q;

	// divider
	logic [DW:0]   dim_q;
	logic [5:0]    bit_q;
	logic [31:0]   mag_q;
	logic [31:0]   quo_q;
	logic [31:0]   rem_q;
	logic          neg_q;
	logic [IDXW-1:0] key_q [NDIMS];

	// scan
	logic [SW:0]   slot_q;
	logic          hit_q, free_ok_q;
	logic [SW-1:0] hit_idx_q, free_q;
	logic          valid_q [CAPACITY];
	logic [IDXW*NDIMS-1:0] mkey [CAPACITY];
	logic signed [31:0]    mcost [CAPACITY];
	logic [IDXW*NDIMS-1:0] mkey_rd_q;
	logic signed [31:0]    mcost_rd_q;
	logic [IDXW*NDIMS-1:0] rkey_q;
	logic signed [31:0]    rcost_q;
	logic          dlast_q;
	logic [31:0]   bv_q [NDIMS];

	// output register
	logic               ovalid_q, olast_q, ofound_q, ofull_q;
	logic signed [31:0] ocost_q;
	logic [IDXW-1:0]    oidx_q [NDIMS];
	logic [31:0]        obv_q [NDIMS];

	logic [SW-1:0] slot_i;
	assign slot_i = slot_q[SW-1:0];

	// slot whose memory word is in the read register during the scan
	logic [SW-1:0] psl;
	assign psl = slot_i - 1'b1;

	// key assembled from quantized indices
	logic [IDXW*NDIMS-1:0] cur_key;
	always_comb begin
		for (int d = 0; d < NDIMS; d++)
			cur_key[d*IDXW +: IDXW] = key_q[d];
	end

	// one restoring divide step
	logic [32:0] trial;
	logic [31:0] rem_sh;
	always_comb begin
		rem_sh = {rem_q[30:0], mag_q[31]};
		trial  = {1'b0, rem_sh} - {2'b00, bsize_q[dim_q[DW-1:0]]};
	end

	// quotient finished: sign and saturation
	logic signed [IDXW-1:0] qidx;
	always_comb begin
		if (bsize_q[dim_q[DW-1:0]] == '0)
			qidx = (feat_q[dim_q[DW-1:0]] == '0) ? '0 : (neg_q ? IDX_MIN : IDX_MAX);
		else if (neg_q)
			qidx = (quo_q > 32'd32768) ? IDX_MIN : IDXW'(-quo_q);
		else
			qidx = (quo_q > 32'd32767) ? IDX_MAX : IDXW'(quo_q);
	end

	// saturating add
	logic signed [32:0] sum;
	logic signed [31:0] sum_sat;
	always_comb begin
		sum = 33'(rcost_q) + 33'(delta_q);
		if (sum > 33'(C_MAX))      sum_sat = C_MAX;
		else if (sum < 33'(C_MIN)) sum_sat = C_MIN;
		else                       sum_sat = sum[31:0];
	end

	// one bucket value product per cycle
	logic signed [IDXW-1:0] bv_idx;
	logic signed [47:0]     prod;
	logic [31:0]            bv_sat;
	always_comb begin
		bv_idx = rkey_q[dim_q[DW-1:0]*IDXW +: IDXW];
		prod   = 48'(bv_idx) * $signed({17'd0, bsize_q[dim_q[DW-1:0]]});
		if (prod > 48'(C_MAX))      bv_sat = C_MAX;
		else if (prod < 48'(C_MIN)) bv_sat = C_MIN;
		else                        bv_sat = prod[31:0];
	end

	logic out_free;
	assign out_free = !ovalid_q || m_axis_tready;

	// a result enters the output register
	logic out_load;
	assign out_load = out_free && (state_q == ST_RES || state_q == ST_DOUT);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				case (op_t'(s_axis_tdata[1:0]))
					OP_CLEAR: state_n = ST_RES;
					OP_DUMP:  state_n = ST_DSCAN;
					default:  state_n = ST_DIV;
				endcase
			end
			ST_DIV: if (bit_q == 6'd32 && dim_q == ND - 1'b1) state_n = ST_SCAN;
			ST_SCAN: if (slot_q == CAP) state_n = ST_UPD;
			ST_UPD: state_n = ST_DMUL;
			ST_RES: if (out_free) state_n = ST_IDLE;
			ST_DSCAN: begin
				if (valid_q[slot_i]) state_n = ST_DRD;
				else if (slot_q == CAP - 1'b1) state_n = ST_IDLE;
			end
			ST_DRD: state_n = ST_DMUL;
			ST_DMUL: if (dim_q == ND - 1'b1) state_n = (op_q == OP_DUMP) ? ST_DOUT : ST_RES;
			ST_DOUT: if (out_free) state_n = (dlast_q) ? ST_IDLE : ST_DSCAN;
			default: state_n = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
	end

	// whether a valid slot lies after the current position, for the dump flag
	logic later_valid;
	always_comb begin
		later_valid = 1'b0;
		for (int i = 0; i < CAPACITY; i++)
			if (SW'(i) > slot_i && valid_q[i]) later_valid = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			for (int i = 0; i < CAPACITY; i++) valid_q[i] <= 1'b0;
			for (int d = 0; d < NDIMS; d++) bsize_q[d] <= 31'd65536;
		end else begin
			state_q <= state_n;
			if (cfg_we) bsize_q[cfg_index] <= cfg_data;
			if (out_load) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && op_t'(s_axis_tdata[1:0]) == OP_CLEAR)
					for (int i = 0; i < CAPACITY; i++) valid_q[i] <= 1'b0;
				ST_UPD: if (op_q == OP_ADD && !hit_q && free_ok_q)
					valid_q[free_q] <= 1'b1;
				default: ;
			endcase
		end
	end

	// registered read port of the key and cost memories
	always_ff @(posedge clk) begin
		mkey_rd_q  <= mkey[slot_i];
		mcost_rd_q <= mcost[slot_i];
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) begin
				op_q    <= op_t'(s_axis_tdata[1:0]);
				for (int d = 0; d < NDIMS; d++) begin
					feat_q[d] <= s_axis_tdata[2 + d*FEATW +: FEATW];
					key_q[d]  <= '0;
				end
				delta_q <= s_axis_tdata[161:130];
				dim_q   <= '0;
				bit_q   <= '0;
				slot_q  <= '0;
				hit_q   <= 1'b0;
				free_ok_q <= 1'b0;
				neg_q   <= s_axis_tdata[33];
				mag_q   <= s_axis_tdata[33] ? -s_axis_tdata[33:2] : s_axis_tdata[33:2];
				rem_q   <= '0;
				quo_q   <= '0;
			end
			ST_DIV: begin
				if (bit_q != 6'd32) begin
					mag_q <= {mag_q[30:0], 1'b0};
					bit_q <= bit_q + 1'b1;
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[30:0], 1'b0};
					end
				end else begin
					key_q[dim_q[DW-1:0]] <= qidx;
					if (dim_q != ND - 1'b1) begin
						dim_q <= dim_q + 1'b1;
						bit_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						neg_q <= feat_q[dim_q[DW-1:0] + 1'b1][31];
						mag_q <= feat_q[dim_q[DW-1:0] + 1'b1][31]
							? -feat_q[dim_q[DW-1:0] + 1'b1] : feat_q[dim_q[DW-1:0] + 1'b1];
					end
				end
			end
			ST_SCAN: begin
				slot_q <= slot_q + 1'b1;
				// the read register holds the slot before slot_q
				if (slot_q != '0) begin
					if (valid_q[psl] && !hit_q && mkey_rd_q == cur_key) begin
						hit_q     <= 1'b1;
						hit_idx_q <= psl;
						rcost_q   <= mcost_rd_q;
					end
					if (!valid_q[psl] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q    <= psl;
					end
				end
			end
			ST_UPD: begin
				if (op_q == OP_ADD) begin
					if (hit_q) begin
						mcost[hit_idx_q] <= sum_sat;
						rcost_q <= sum_sat;
					end else if (free_ok_q) begin
						mkey[free_q]  <= cur_key;
						mcost[free_q] <= delta_q;
						rcost_q <= delta_q;
					end else rcost_q <= '0;
				end else if (!hit_q) rcost_q <= '0;
				rkey_q <= cur_key;
				dim_q  <= '0;
				for (int d = 0; d < NDIMS; d++) bv_q[d] <= '0;
			end
			ST_RES: if (out_free) begin
				olast_q  <= 1'b1;
				ofound_q <= (op_q != OP_CLEAR) && hit_q;
				ofull_q  <= (op_q == OP_ADD) && !hit_q && !free_ok_q;
				ocost_q  <= (op_q == OP_CLEAR) ? '0 : rcost_q;
				for (int d = 0; d < NDIMS; d++) begin
					oidx_q[d] <= (op_q == OP_CLEAR || d >= DIMS) ? '0 : key_q[d];
					obv_q[d]  <= (op_q == OP_CLEAR) ? '0 : bv_q[d];
				end
			end
			ST_DSCAN: begin
				if (valid_q[slot_i]) dlast_q <= !later_valid;
				else slot_q <= slot_q + 1'b1;
				dim_q <= '0;
			end
			ST_DRD: begin
				rkey_q  <= mkey_rd_q;
				rcost_q <= mcost_rd_q;
				for (int d = 0; d < NDIMS; d++) bv_q[d] <= '0;
			end
			ST_DMUL: begin
				bv_q[dim_q[DW-1:0]] <= bv_sat;
				dim_q <= dim_q + 1'b1;
			end
			ST_DOUT: if (out_free) begin
				slot_q   <= slot_q + 1'b1;
				olast_q  <= dlast_q;
				ofound_q <= 1'b1;
				ofull_q  <= 1'b0;
				ocost_q  <= rcost_q;
				for (int d = 0; d < NDIMS; d++) begin
					oidx_q[d] <= (d >= DIMS) ? '0 : rkey_q[d*IDXW +: IDXW];
					obv_q[d]  <= bv_q[d];
				end
			end
			default: ;
		endcase
	end

	// bucket values of the held result
	logic [31:0] rbv [NDIMS];
	always_comb begin
		for (int d = 0; d < NDIMS; d++) rbv[d] = obv_q[d];
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tlast  = olast_q;
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[31:0] = ocost_q;
		m_axis_tdata[32]   = ofound_q;
		m_axis_tdata[33]   = ofull_q;
		for (int d = 0; d < NDIMS; d++) begin
			m_axis_tdata[34 + d*IDXW +: IDXW] = oidx_q[d];
			m_axis_tdata[98 + d*32 +: 32]     = rbv[d];
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == ST_IDLE) else $error("accept while busy");
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(ofound_q && ofull_q)) else $error("found and full");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
endmodule
`default_nettype wire
